// ----- rtl/core/kmer_union_merge_filter_core_defines.svh -----
// ---------------------------------------------------------------------------
// kmer_union_merge_filter_core_defines.svh
// Assertion macros shared by the merge filter core.
// ---------------------------------------------------------------------------
`ifndef KMER_UNION_MERGE_FILTER_CORE_DEFINES_SVH
`define KMER_UNION_MERGE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define KUMF_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define KUMF_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/kumf_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kumf_pkg
// Widths, register indexes and item codes of the k-mer merge filter.
// ---------------------------------------------------------------------------
package kumf_pkg;

	localparam int MAX_SRC  = 16;
	localparam int SRC_W    = 4;
	localparam int FC_W     = 5;
	localparam int KMER_W   = 64;
	localparam int CNT_W    = 32;
	localparam int SCALE_W  = 32;
	localparam int VAL_W    = 48;
	localparam int PROD_W   = CNT_W + SCALE_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_A       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_B       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MASK  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT       = 3'd6;

	// input op codes
	localparam logic OP_SCALE  = 1'b0;
	localparam logic OP_RECORD = 1'b1;

	// result kinds
	localparam logic KIND_REQ = 1'b0;
	localparam logic KIND_ROW = 1'b1;

	// merge phases
	localparam logic [1:0] PH_LOAD = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
	localparam logic [FC_W-1:0]  TALLY_MAX = {FC_W{1'b1}};

endpackage

// ----- rtl/core/kumf_rec_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kumf_rec_if
// Input item channel: scale loads and source records.
// ---------------------------------------------------------------------------
interface kumf_rec_if
	import kumf_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               op;
	logic [SRC_W-1:0]   source;
	logic [KMER_W-1:0]  kmer;
	logic [CNT_W-1:0]   count;
	logic [SCALE_W-1:0] scale;
	logic               exhausted;

	modport source_mp (output valid, op, source, kmer, count, scale, exhausted, input ready);
	modport sink (input valid, op, source, kmer, count, scale, exhausted, output ready);
endinterface

// ----- rtl/core/kumf_res_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kumf_res_if
// Result item channel: record requests and row values.
// ---------------------------------------------------------------------------
interface kumf_res_if
	import kumf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [SRC_W-1:0]  source_res;
	logic [KMER_W-1:0] row_kmer;
	logic [VAL_W-1:0]  value;
	logic              last;

	modport source_mp (output valid, kind, source_res, row_kmer, value, last, input ready);
	modport sink (input valid, kind, source_res, row_kmer, value, last, output ready);
endinterface

// ----- rtl/core/kumf_cfg_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kumf_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface kumf_cfg_if
	import kumf_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source_mp (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/kumf_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kumf_ram
// Generic one-write one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kumf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/kmer_union_merge_filter_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmer_union_merge_filter_core
// K-way merge of sorted k-mer count streams with row gathering and filter.
// ---------------------------------------------------------------------------
// Use: write the registers on cfg while idle, then send one scale item per
// source and each source's first record on rec. Once every source has its
// first record the block picks the smallest k-mer and issues a request item
// on res naming the source whose next record it needs; answer each request
// with that source's record. Equal k-mers gather into one row; a row that
// closes and meets a tally threshold leaves as file_count row value items,
// the very last one flagged with last.
// A scale item or an ignored record is handled in the idle state. A record
// that advances the merge puts its request item on res after a scan of the
// leaf k-mer memory (one entry per cycle through its single read port, with
// registered read data and a settle step), a decide state, the count and
// scale read, the multiply and the row write, and the load of the output
// register, which waits while the receiver stalls. When a closing row
// passes, its columns are read from the row memory and emitted one by one
// before the gather goes on. One item is worked at a time; rec.ready is high
// only when the block is idle.
// Reset clears all control state and the merge restarts in the load phase;
// memory contents are not cleared. A stalled receiver holds the output
// register and the block waits on it.
// ---------------------------------------------------------------------------
`include "kmer_union_merge_filter_core_defines.svh"

module kmer_union_merge_filter_core
	import kumf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	kumf_rec_if.sink      rec,
	kumf_res_if.source_mp res,
	kumf_cfg_if.sink      cfg
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_DECIDE = 4'd2;
	localparam logic [3:0] ST_G_RD   = 4'd3;
	localparam logic [3:0] ST_G_MUL  = 4'd4;
	localparam logic [3:0] ST_G_WR   = 4'd5;
	localparam logic [3:0] ST_REQ    = 4'd6;
	localparam logic [3:0] ST_F_RD   = 4'd7;
	localparam logic [3:0] ST_F_EM   = 4'd8;

	// configuration registers
	logic [FC_W-1:0]    file_count_q;
	logic [KMER_W-1:0]  range_start_q;
	logic [KMER_W-1:0]  range_end_q;
	logic [FC_W-1:0]    thr_a_q;
	logic [FC_W-1:0]    thr_b_q;
	logic [MAX_SRC-1:0] mask_q;
	logic               split_q;

	// control state
	logic [3:0]         state_q;
	logic [1:0]         phase_q;
	logic [MAX_SRC-1:0] loaded_q;
	logic [MAX_SRC-1:0] done_q;
	logic [MAX_SRC-1:0] rv_q;
	logic [SRC_W-1:0]   pend_q;
	logic               row_open_q;
	logic [FC_W-1:0]    tally_a_q;
	logic [FC_W-1:0]    tally_b_q;
	logic [FC_W-1:0]    scan_q;
	logic               scan_v_s1;
	logic [SRC_W-1:0]   scan_idx_s1;
	logic               best_found_q;
	logic [SRC_W-1:0]   best_idx_q;
	logic [KMER_W-1:0]  best_kmer_q;
	logic [KMER_W-1:0]  cur_kmer_q;
	logic               fl_final_q;
	logic [SRC_W-1:0]   col_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic               out_kind_q;
	logic [SRC_W-1:0]   out_src_q;
	logic [KMER_W-1:0]  out_kmer_q;
	logic [VAL_W-1:0]   out_val_q;
	logic               out_last_q;

	// memory ports
	logic [KMER_W-1:0]  kmer_rd;
	logic [CNT_W-1:0]   cnt_rd;
	logic [SCALE_W-1:0] scale_rd;
	logic [VAL_W-1:0]   row_rd;
	logic               leaf_we;
	logic               scale_we;
	logic               row_we;
	logic [VAL_W-1:0]   row_wdata;

	// derived values
	logic [FC_W-1:0]    fc_eff;
	logic [SRC_W-1:0]   fc_last;
	logic [MAX_SRC-1:0] fc_mask;
	logic [MAX_SRC-1:0] live;
	logic               rec_acc;
	logic               is_rec;
	logic               ends;
	logic               load_ok;
	logic               run_ok;
	logic               take;
	logic [MAX_SRC-1:0] loaded_nxt;
	logic               out_free;
	logic               out_load;
	logic               passes;
	logic [PROD_W:0]    rnd_sum;
	logic [PROD_W-8:0]  rnd_shr;
	logic               in_a;

	// clamp source count and build the source masks
	always_comb begin
		if (file_count_q == '0) begin
			fc_eff = FC_W'(1);
		end else if (file_count_q > FC_W'(MAX_SRC)) begin
			fc_eff = FC_W'(MAX_SRC);
		end else begin
			fc_eff = file_count_q;
		end
		fc_last = SRC_W'(fc_eff - FC_W'(1));
		for (int i = 0; i < MAX_SRC; i++) begin
			fc_mask[i] = FC_W'(i) < fc_eff;
		end
		live = loaded_q & ~done_q & fc_mask;
	end

	// classify the accepted item
	assign rec.ready = (state_q == ST_IDLE);
	assign rec_acc   = rec.valid && rec.ready;
	assign is_rec    = rec.op == OP_RECORD;
	assign ends      = rec.exhausted || (rec.kmer >= range_end_q);
	assign load_ok   = (phase_q == PH_LOAD) && fc_mask[rec.source] && !loaded_q[rec.source]
		&& (rec.exhausted || (rec.kmer >= range_start_q));
	assign run_ok    = (phase_q == PH_RUN) && (rec.source == pend_q);
	assign take      = rec_acc && is_rec && (load_ok || run_ok);
	assign leaf_we   = take && !ends;
	assign scale_we  = rec_acc && !is_rec;
	assign loaded_nxt = loaded_q | (MAX_SRC'(1) << rec.source);

	assign out_free = !out_valid_q || res.ready;
	assign out_load = out_free && (state_q == ST_REQ || state_q == ST_F_EM);
	assign passes   = (tally_a_q >= thr_a_q) || (tally_b_q >= thr_b_q);

	// round half up and saturate the scaled count
	assign rnd_sum   = {1'b0, prod_q} + (PROD_W+1)'(128);
	assign rnd_shr   = rnd_sum[PROD_W:8];
	assign row_wdata = (rnd_shr > (PROD_W-7)'(VAL_MAX)) ? VAL_MAX : rnd_shr[VAL_W-1:0];
	assign row_we    = state_q == ST_G_WR;
	assign in_a      = !split_q || mask_q[best_idx_q];

	kumf_ram #(.WIDTH(KMER_W), .DEPTH(MAX_SRC)) u_kmer_ram (
		.clk(clk), .we(leaf_we), .waddr(rec.source), .wdata(rec.kmer),
		.re(state_q == ST_SCAN && !scan_q[FC_W-1]), .raddr(scan_q[SRC_W-1:0]),
		.rdata(kmer_rd)
	);

	kumf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SRC)) u_cnt_ram (
		.clk(clk), .we(leaf_we), .waddr(rec.source), .wdata(rec.count),
		.re(state_q == ST_G_RD), .raddr(best_idx_q), .rdata(cnt_rd)
	);

	kumf_ram #(.WIDTH(SCALE_W), .DEPTH(MAX_SRC)) u_scale_ram (
		.clk(clk), .we(scale_we), .waddr(rec.source), .wdata(rec.scale),
		.re(state_q == ST_G_RD), .raddr(best_idx_q), .rdata(scale_rd)
	);

	kumf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SRC)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(best_idx_q), .wdata(row_wdata),
		.re(state_q == ST_F_RD), .raddr(col_q), .rdata(row_rd)
	);

	// configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_count_q  <= FC_W'(1);
			range_start_q <= '0;
			range_end_q   <= '1;
			thr_a_q       <= FC_W'(1);
			thr_b_q       <= FC_W'(1);
			mask_q        <= '1;
			split_q       <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FILE_COUNT:  file_count_q  <= cfg.data[FC_W-1:0];
				CFG_RANGE_START: range_start_q <= cfg.data;
				CFG_RANGE_END:   range_end_q   <= cfg.data;
				CFG_THR_A:       thr_a_q       <= cfg.data[FC_W-1:0];
				CFG_THR_B:       thr_b_q       <= cfg.data[FC_W-1:0];
				CFG_GROUP_MASK:  mask_q        <= cfg.data[MAX_SRC-1:0];
				CFG_SPLIT:       split_q       <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_G_MUL) begin
			prod_q <= PROD_W'(cnt_rd) * PROD_W'(scale_rd);
		end
		if (state_q == ST_SCAN) begin
			scan_idx_s1 <= scan_q[SRC_W-1:0];
		end
		if (state_q == ST_SCAN && scan_v_s1 && live[scan_idx_s1]
			&& (!best_found_q || kmer_rd < best_kmer_q)) begin
			best_idx_q  <= scan_idx_s1;
			best_kmer_q <= kmer_rd;
		end
		if (state_q == ST_G_WR) begin
			cur_kmer_q <= best_kmer_q;
		end
	end

	// merge sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_LOAD;
			loaded_q     <= '0;
			done_q       <= '0;
			rv_q         <= '0;
			pend_q       <= '0;
			row_open_q   <= 1'b0;
			tally_a_q    <= '0;
			tally_b_q    <= '0;
			scan_q       <= '0;
			scan_v_s1    <= 1'b0;
			best_found_q <= 1'b0;
			fl_final_q   <= 1'b0;
			col_q        <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_REQ;
			out_src_q    <= '0;
			out_kmer_q   <= '0;
			out_val_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// load or drain the output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						loaded_q <= loaded_nxt;
						if (ends) begin
							done_q[rec.source] <= 1'b1;
						end
						// start a scan once all first records are in, or on each record taken in the run phase
						if (phase_q == PH_RUN || (loaded_nxt & fc_mask) == fc_mask) begin
							state_q      <= ST_SCAN;
							scan_q       <= '0;
							scan_v_s1    <= 1'b0;
							best_found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					scan_v_s1 <= !scan_q[FC_W-1];
					if (!scan_q[FC_W-1]) begin
						scan_q <= scan_q + FC_W'(1);
					end else if (!scan_v_s1) begin
						state_q <= ST_DECIDE;
					end
					if (scan_v_s1 && live[scan_idx_s1]
						&& (!best_found_q || kmer_rd < best_kmer_q)) begin
						best_found_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					col_q <= '0;
					if (!best_found_q) begin
						fl_final_q <= 1'b1;
						if (row_open_q) begin
							state_q <= passes ? ST_F_RD : ST_IDLE;
							if (!passes) begin
								rv_q       <= '0;
								tally_a_q  <= '0;
								tally_b_q  <= '0;
								row_open_q <= 1'b0;
								phase_q    <= PH_DONE;
							end
						end else begin
							phase_q <= PH_DONE;
							state_q <= ST_IDLE;
						end
					end else begin
						fl_final_q <= 1'b0;
						phase_q    <= PH_RUN;
						if (row_open_q && best_kmer_q != cur_kmer_q) begin
							state_q <= passes ? ST_F_RD : ST_G_RD;
							if (!passes) begin
								rv_q       <= '0;
								tally_a_q  <= '0;
								tally_b_q  <= '0;
								row_open_q <= 1'b0;
							end
						end else begin
							state_q <= ST_G_RD;
						end
					end
				end
				ST_G_RD: begin
					state_q <= ST_G_MUL;
				end
				ST_G_MUL: begin
					state_q <= ST_G_WR;
				end
				ST_G_WR: begin
					// add the source to the row and its tally
					rv_q[best_idx_q] <= 1'b1;
					if (in_a) begin
						if (tally_a_q != TALLY_MAX) begin
							tally_a_q <= tally_a_q + FC_W'(1);
						end
					end else begin
						if (tally_b_q != TALLY_MAX) begin
							tally_b_q <= tally_b_q + FC_W'(1);
						end
					end
					row_open_q <= 1'b1;
					pend_q     <= best_idx_q;
					state_q    <= ST_REQ;
				end
				ST_REQ: begin
					if (out_free) begin
						out_kind_q  <= KIND_REQ;
						out_src_q   <= pend_q;
						out_kmer_q  <= '0;
						out_val_q   <= '0;
						out_last_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_F_RD: begin
					state_q <= ST_F_EM;
				end
				ST_F_EM: begin
					if (out_free) begin
						out_kind_q  <= KIND_ROW;
						out_src_q   <= col_q;
						out_kmer_q  <= cur_kmer_q;
						out_val_q   <= rv_q[col_q] ? row_rd : '0;
						out_last_q  <= fl_final_q && (col_q == fc_last);
						if (col_q == fc_last) begin
							// close the row
							rv_q       <= '0;
							tally_a_q  <= '0;
							tally_b_q  <= '0;
							row_open_q <= 1'b0;
							if (fl_final_q) begin
								phase_q <= PH_DONE;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_G_RD;
							end
						end else begin
							col_q   <= col_q + SRC_W'(1);
							state_q <= ST_F_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = out_kind_q;
	assign res.source_res = out_src_q;
	assign res.row_kmer   = out_kmer_q;
	assign res.value      = out_val_q;
	assign res.last       = out_last_q;

	// checks
	`KUMF_ASSERT_NEXT(a_done_sticky, clk, arst_n, phase_q == PH_DONE,
		phase_q == PH_DONE, "merge left the done phase")
	`KUMF_ASSERT_NOW(a_req_clean, clk, arst_n, res.valid && res.kind == KIND_REQ,
		res.value == '0 && res.row_kmer == '0, "request item carries row data")
	`KUMF_ASSERT_NOW(a_tally_open, clk, arst_n, tally_a_q != '0 || tally_b_q != '0,
		row_open_q, "tally counted with no open row")
	`KUMF_ASSERT_NOW(a_pend_loaded, clk, arst_n, phase_q == PH_RUN && state_q == ST_IDLE,
		loaded_q[pend_q], "pending source was never loaded")

endmodule
